// ===== rtl/lsw_pkg.sv =====
// Package for the lap stopwatch with input trace.
// Holds sizing constants, field widths, operation and status codes.
// No dependencies.
package lsw_pkg;

    localparam int MAX_SPLITS    = 32;
    localparam int HISTORY_DEPTH = 64;
    localparam int FRAME_BITS    = 48;

    localparam int REQ_W     = 3;
    localparam int MASK_W    = 10;
    localparam int INDEX_W   = 6;
    localparam int NEW_W     = 48;
    localparam int ELAPSED_W = 48;
    localparam int SPLIT_N_W = 6;
    localparam int HIST_N_W  = 7;
    localparam int DATA_W    = 48;
    localparam int STATUS_W  = 2;

    localparam int SPLIT_AW  = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;
    localparam int SPLIT_CW  = $clog2(MAX_SPLITS + 1);
    localparam int HIST_AW   = $clog2(HISTORY_DEPTH);
    localparam int HIST_CW   = $clog2(HISTORY_DEPTH + 1);

    typedef logic [FRAME_BITS-1:0] frame_t;

    typedef enum logic [REQ_W-1:0] {
        OP_TICK   = 3'd0,
        OP_RESET  = 3'd1,
        OP_TOGGLE = 3'd2,
        OP_SPLIT  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_RD_SPL = 3'd5,
        OP_RD_HIS = 3'd6,
        OP_LOAD   = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_SPLIT,
        SRC_HIST
    } rd_src_t;

endpackage

// ===== rtl/lsw_in_if.sv =====
// Command channel of the lap stopwatch: valid/ready handshake and item fields.
// Depends on lsw_pkg.
interface lsw_in_if;
    import lsw_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [MASK_W-1:0]  button_mask;
    logic [INDEX_W-1:0] read_index;
    logic [NEW_W-1:0]   new_frame;

    modport source (output valid, req_type, button_mask, read_index, new_frame, input ready);
    modport sink   (input valid, req_type, button_mask, read_index, new_frame, output ready);
endinterface

// ===== rtl/lsw_out_if.sv =====
// Result channel of the lap stopwatch: valid/ready handshake and item fields.
// Depends on lsw_pkg.
interface lsw_out_if;
    import lsw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ELAPSED_W-1:0] elapsed_frames;
    logic                 is_running;
    logic [SPLIT_N_W-1:0] split_total;
    logic [HIST_N_W-1:0]  history_total;
    logic [MASK_W-1:0]    latest_mask;
    logic [DATA_W-1:0]    read_data;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, elapsed_frames, is_running, split_total, history_total,
                    latest_mask, read_data, status, input ready);
    modport sink   (input valid, elapsed_frames, is_running, split_total, history_total,
                    latest_mask, read_data, status, output ready);
endinterface

// ===== rtl/lap_stopwatch_with_input_trace_top.sv =====
// A result passes through the middle stage, then the output register, after its command
// is accepted; it waits there while the result channel stalls. Throughput: one item per
// cycle unless the result channel stalls; the state update and both RAM accesses are done
// in the accept cycle, and the registered RAM read is merged as the item leaves the middle stage.
// Reset (rst_n, asynchronous, active low) clears counters, base, stop point and
// fill counts and sets the run flag; the split and history RAMs are not cleared.
// Top level of the lap stopwatch with input trace; depends on lsw_pkg,
// lsw_in_if, lsw_out_if and lsw_ram.
module lap_stopwatch_with_input_trace_top (
    input  logic        clk,
    input  logic        rst_n,
    lsw_in_if.sink      cmd,
    lsw_out_if.source   result
);
    import lsw_pkg::*;

    // Architectural state.
    frame_t                fc_reg,   fc_next;
    frame_t                base_reg, base_next;
    frame_t                stop_reg, stop_next;
    logic                  run_reg,  run_next;
    logic [SPLIT_CW-1:0]   su_reg,   su_next;
    logic [HIST_AW-1:0]    head_reg, head_next;
    logic [HIST_CW-1:0]    ru_reg,   ru_next;
    logic [MASK_W-1:0]     lm_reg,   lm_next;

    // Middle stage, waiting for RAM read data.
    logic                  s1_valid_reg;
    logic [ELAPSED_W-1:0]  s1_elapsed_reg;
    logic                  s1_run_reg;
    logic [SPLIT_CW-1:0]   s1_su_reg;
    logic [HIST_CW-1:0]    s1_ru_reg;
    logic [MASK_W-1:0]     s1_mask_reg;
    rd_src_t               s1_src_reg;
    status_t               s1_status_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [ELAPSED_W-1:0]  out_elapsed_reg;
    logic                  out_run_reg;
    logic [SPLIT_N_W-1:0]  out_su_reg;
    logic [HIST_N_W-1:0]   out_ru_reg;
    logic [MASK_W-1:0]     out_mask_reg;
    logic [DATA_W-1:0]     out_data_reg;
    status_t               out_status_reg;

    logic                  accept;
    logic                  s1_move;
    op_t                   op;
    frame_t                fc1, base1, stop1, point;
    logic                  run1, behind;
    frame_t                elapsed;
    status_t               status_c;
    rd_src_t               src_c;
    logic                  split_has_room;
    logic                  split_idx_ok;
    logic                  hist_idx_ok;
    logic [HIST_AW:0]      hist_pos_sum;
    logic [HIST_AW-1:0]    hist_pos;
    logic                  split_we;
    logic                  hist_we;
    logic [DATA_W-1:0]     split_rdata;
    logic [MASK_W-1:0]     hist_rdata;
    logic [DATA_W-1:0]     read_data_c;

    assign op      = op_t'(cmd.req_type);
    assign s1_move = s1_valid_reg && (!out_valid_reg || result.ready);
    assign cmd.ready = !s1_valid_reg || s1_move;
    assign accept  = cmd.valid && cmd.ready;

    assign split_has_room = (32'(su_reg) < 32'(MAX_SPLITS));
    assign split_idx_ok   = (32'(cmd.read_index) < 32'(su_reg));
    assign hist_idx_ok    = (32'(cmd.read_index) < 32'(ru_reg));

    assign hist_pos_sum = {1'b0, head_reg} + (HIST_AW + 1)'(HISTORY_DEPTH - 1)
                          - (HIST_AW + 1)'(cmd.read_index);
    assign hist_pos     = (32'(hist_pos_sum) >= 32'(HISTORY_DEPTH))
                          ? HIST_AW'(32'(hist_pos_sum) - 32'(HISTORY_DEPTH))
                          : HIST_AW'(hist_pos_sum);

    always_comb
    begin
        fc1       = fc_reg;
        base1     = base_reg;
        stop1     = stop_reg;
        run1      = run_reg;
        su_next   = su_reg;
        head_next = head_reg;
        ru_next   = ru_reg;
        lm_next   = lm_reg;
        status_c  = ST_OK;
        src_c     = SRC_NONE;
        split_we  = 1'b0;
        hist_we   = 1'b0;

        unique case (op)
            OP_TICK:
            begin
                fc1     = fc_reg + frame_t'(1);
                lm_next = cmd.button_mask;
                hist_we = 1'b1;
                head_next = (32'(head_reg) == 32'(HISTORY_DEPTH - 1))
                            ? '0 : head_reg + HIST_AW'(1);
                if (32'(ru_reg) < 32'(HISTORY_DEPTH))
                begin
                    ru_next = ru_reg + HIST_CW'(1);
                end
            end
            OP_RESET:
            begin
                base1 = fc_reg;
                stop1 = fc_reg;
            end
            OP_TOGGLE:
            begin
                if (run_reg)
                begin
                    stop1 = fc_reg;
                    run1  = 1'b0;
                end
                else
                begin
                    if (fc_reg >= stop_reg)
                    begin
                        base1 = base_reg + (fc_reg - stop_reg);
                    end
                    run1 = 1'b1;
                end
            end
            OP_SPLIT:
            begin
                if (split_has_room)
                begin
                    split_we = 1'b1;
                    su_next  = su_reg + SPLIT_CW'(1);
                end
                else
                begin
                    status_c = ST_FULL;
                end
            end
            OP_CLEAR:
            begin
                su_next = '0;
            end
            OP_RD_SPL:
            begin
                if (split_idx_ok)
                begin
                    src_c = SRC_SPLIT;
                end
                else
                begin
                    status_c = ST_RANGE;
                end
            end
            OP_RD_HIS:
            begin
                if (hist_idx_ok)
                begin
                    src_c = SRC_HIST;
                end
                else
                begin
                    status_c = ST_RANGE;
                end
            end
            OP_LOAD:
            begin
                fc1 = frame_t'(cmd.new_frame);
            end
            default:
            begin
                fc1 = fc_reg;
            end
        endcase

        // The reading re-anchors to zero whenever the point in use is behind the base.
        point  = run1 ? fc1 : stop1;
        behind = (point < base1);
        if (behind)
        begin
            elapsed   = '0;
            base_next = point;
            stop_next = point;
        end
        else
        begin
            elapsed   = point - base1;
            base_next = base1;
            stop_next = stop1;
        end
        fc_next  = fc1;
        run_next = run1;
    end

    lsw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_SPLITS)
    ) u_split_ram (
        .clk   (clk),
        .we    (accept && split_we),
        .waddr (SPLIT_AW'(su_reg)),
        .wdata (DATA_W'(elapsed)),
        .re    (accept),
        .raddr (SPLIT_AW'(cmd.read_index)),
        .rdata (split_rdata)
    );

    lsw_ram #(
        .WIDTH (MASK_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (accept && hist_we),
        .waddr (head_reg),
        .wdata (cmd.button_mask),
        .re    (accept),
        .raddr (hist_pos),
        .rdata (hist_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg   <= '0;
            base_reg <= '0;
            stop_reg <= '0;
            run_reg  <= 1'b1;
            su_reg   <= '0;
            head_reg <= '0;
            ru_reg   <= '0;
            lm_reg   <= '0;
        end
        else if (accept)
        begin
            fc_reg   <= fc_next;
            base_reg <= base_next;
            stop_reg <= stop_next;
            run_reg  <= run_next;
            su_reg   <= su_next;
            head_reg <= head_next;
            ru_reg   <= ru_next;
            lm_reg   <= lm_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_elapsed_reg <= ELAPSED_W'(elapsed);
            s1_run_reg     <= run_next;
            s1_su_reg      <= su_next;
            s1_ru_reg      <= ru_next;
            s1_mask_reg    <= lm_next;
            s1_src_reg     <= src_c;
            s1_status_reg  <= status_c;
        end
        if (s1_move)
        begin
            out_elapsed_reg <= s1_elapsed_reg;
            out_run_reg     <= s1_run_reg;
            out_su_reg      <= SPLIT_N_W'(s1_su_reg);
            out_ru_reg      <= HIST_N_W'(s1_ru_reg);
            out_mask_reg    <= s1_mask_reg;
            out_data_reg    <= read_data_c;
            out_status_reg  <= s1_status_reg;
        end
    end

    always_comb
    begin
        unique case (s1_src_reg)
            SRC_SPLIT: read_data_c = split_rdata;
            SRC_HIST:  read_data_c = DATA_W'(hist_rdata);
            default:   read_data_c = '0;
        endcase
    end

    assign result.valid          = out_valid_reg;
    assign result.elapsed_frames = out_elapsed_reg;
    assign result.is_running     = out_run_reg;
    assign result.split_total    = out_su_reg;
    assign result.history_total  = out_ru_reg;
    assign result.latest_mask    = out_mask_reg;
    assign result.read_data      = out_data_reg;
    assign result.status         = out_status_reg;

    a_split_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(su_reg) <= 32'(MAX_SPLITS))
        else $error("split count exceeds table size");

    a_hist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ru_reg) <= 32'(HISTORY_DEPTH))
        else $error("history count exceeds ring depth");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> s1_valid_reg)
        else $error("middle stage item lost while stalled");

    a_tick_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_TICK) |=> (ru_reg != '0))
        else $error("history count empty after a tick");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_RANGE) |-> (out_data_reg == '0))
        else $error("out-of-range read returned nonzero data");

endmodule

// ===== rtl/lsw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/sv/lsw_checker.sv =====
// Checker for the lap stopwatch: watches the command and result channels,
// predicts each readout from the accepted commands and compares it with the block.
// Depends on lsw_pkg, lsw_in_if and lsw_out_if.
`timescale 1ns / 100ps
module lsw_checker (
    input  logic clk,
    input  logic rst_n,
    lsw_in_if    cmd,
    lsw_out_if   result,
    output int   fail_count,
    output int   pending
);
    import lsw_pkg::*;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        logic                 running;
        logic [SPLIT_N_W-1:0] splits;
        logic [HIST_N_W-1:0]  samples;
        logic [MASK_W-1:0]    buttons;
        logic [DATA_W-1:0]    data;
        logic [STATUS_W-1:0]  status;
    } readout_t;

    frame_t              frame_cnt;
    frame_t              base_pt;
    frame_t              stop_pt;
    logic                run_flag;
    frame_t              lap_mem [MAX_SPLITS];
    logic [SPLIT_CW-1:0] lap_cnt;
    logic [MASK_W-1:0]   trace_mem [HISTORY_DEPTH];
    logic [HIST_AW-1:0]  trace_head;
    logic [HIST_CW-1:0]  trace_cnt;
    logic [MASK_W-1:0]   last_buttons;
    readout_t            readout_q [$];
    int                  mismatches;

    // A reading behind the base pulls the base and the stop point back to it.
    function automatic frame_t watch_reading();
        frame_t point;
        point = run_flag ? frame_cnt : stop_pt;
        if (point < base_pt)
        begin
            base_pt = point;
            stop_pt = point;
            return '0;
        end
        return point - base_pt;
    endfunction

    function automatic readout_t predict_readout(op_t op, logic [MASK_W-1:0] buttons,
                                                 logic [INDEX_W-1:0] idx, frame_t nf);
        readout_t r;
        int       pos;
        r = '0;
        case (op)
            OP_TICK:
            begin
                frame_cnt             = frame_cnt + 1'b1;
                last_buttons          = buttons;
                trace_mem[trace_head] = buttons;
                trace_head            = HIST_AW'((int'(trace_head) + 1) % HISTORY_DEPTH);
                if (trace_cnt < HISTORY_DEPTH)
                    trace_cnt = trace_cnt + 1'b1;
            end
            OP_RESET:
            begin
                base_pt = frame_cnt;
                stop_pt = frame_cnt;
            end
            OP_TOGGLE:
            begin
                if (run_flag)
                begin
                    stop_pt  = frame_cnt;
                    run_flag = 1'b0;
                end
                else
                begin
                    if (frame_cnt >= stop_pt)
                        base_pt = base_pt + (frame_cnt - stop_pt);
                    run_flag = 1'b1;
                end
            end
            OP_SPLIT:
            begin
                if (lap_cnt >= MAX_SPLITS)
                    r.status = ST_FULL;
                else
                begin
                    lap_mem[SPLIT_AW'(lap_cnt)] = watch_reading();
                    lap_cnt                     = lap_cnt + 1'b1;
                end
            end
            OP_CLEAR:
                lap_cnt = '0;
            OP_RD_SPL:
            begin
                if (idx < lap_cnt)
                    r.data = lap_mem[SPLIT_AW'(idx)];
                else
                    r.status = ST_RANGE;
            end
            OP_RD_HIS:
            begin
                if (idx < trace_cnt)
                begin
                    pos    = (int'(trace_head) + 2 * HISTORY_DEPTH - 1 - int'(idx))
                             % HISTORY_DEPTH;
                    r.data = DATA_W'(trace_mem[HIST_AW'(pos)]);
                end
                else
                    r.status = ST_RANGE;
            end
            OP_LOAD:
                frame_cnt = nf;
            default:
                ;
        endcase
        r.elapsed = watch_reading();
        r.running = run_flag;
        r.splits  = SPLIT_N_W'(lap_cnt);
        r.samples = HIST_N_W'(trace_cnt);
        r.buttons = last_buttons;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        readout_t want;
        readout_t got;
        if (!rst_n)
        begin
            frame_cnt    = '0;
            base_pt      = '0;
            stop_pt      = '0;
            run_flag     = 1'b1;
            lap_cnt      = '0;
            trace_head   = '0;
            trace_cnt    = '0;
            last_buttons = '0;
            readout_q.delete();
            mismatches   = 0;
            fail_count  <= 0;
            pending     <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got = '{elapsed: result.elapsed_frames, running: result.is_running,
                        splits: result.split_total, samples: result.history_total,
                        buttons: result.latest_mask, data: result.read_data,
                        status: result.status};
                if (readout_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: readout with no command waiting for it", $time);
                end
                else
                begin
                    want = readout_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: readout mismatch (expected/actual): %s %h/%h %s %b/%b",
                                     $time, "elapsed", want.elapsed, got.elapsed,
                                     "running", want.running, got.running);
                            $display("    splits %0d/%0d samples %0d/%0d mask %h/%h",
                                     want.splits, got.splits, want.samples, got.samples,
                                     want.buttons, got.buttons);
                            $display("    data %h/%h status %0d/%0d",
                                     want.data, got.data, want.status, got.status);
                        end
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                readout_q.push_back(predict_readout(op_t'(cmd.req_type), cmd.button_mask,
                                                    cmd.read_index, cmd.new_frame));
            fail_count <= mismatches;
            pending    <= readout_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_lap_stopwatch_with_input_trace_top.sv =====
// Testbench top for the lap stopwatch: clock, reset, command stimulus, result
// back-pressure and the verdict. Depends on lsw_pkg, both channel interfaces,
// lsw_checker and the block itself.
`timescale 1ns / 100ps
module tb_lap_stopwatch_with_input_trace_top;
    import lsw_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int LONG_HOLD    = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count   = 0;
    int   hold_requests = 0;
    int   burst_left    = 0;
    int   items_sent    = 0;
    bit   no_gaps       = 1'b0;

    lsw_in_if  cmd_if ();
    lsw_out_if res_if ();

    lap_stopwatch_with_input_trace_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .result (res_if)
    );

    lsw_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_if),
        .result     (res_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[lap_stopwatch_with_input_trace_top] ERROR");
            $finish;
        end
    end

    function automatic op_t pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return OP_TICK;
        if (r < 36) return OP_RESET;
        if (r < 46) return OP_TOGGLE;
        if (r < 62) return OP_SPLIT;
        if (r < 65) return OP_CLEAR;
        if (r < 78) return OP_RD_SPL;
        if (r < 90) return OP_RD_HIS;
        return OP_LOAD;
    endfunction

    function automatic frame_t pick_frame();
        case ($urandom_range(0, 3))
            0:       return frame_t'($urandom_range(0, 63));
            1:       return {FRAME_BITS{1'b1}} - frame_t'($urandom_range(0, 63));
            default: return frame_t'({$urandom(), $urandom()});
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        return MASK_W'($urandom_range(0, 1023));
    endfunction

    task automatic issue(input op_t op, input logic [MASK_W-1:0] mask, input int idx,
                         input frame_t nf);
        int gap;
        if (burst_left == 0 && !no_gaps)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        cmd_if.valid       <= 1'b1;
        cmd_if.req_type    <= op;
        cmd_if.button_mask <= mask;
        cmd_if.read_index  <= INDEX_W'(idx);
        cmd_if.new_frame   <= nf;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic issue_op(input op_t op);
        int idx;
        idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 33);
        issue(op, pick_mask(), idx, pick_frame());
    endtask

    task automatic pause_for_results();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        burst_left = 0;
    endtask

    // The receiver stalls for a long stretch while commands keep coming back to back.
    task automatic held_burst();
        hold_requests <= hold_requests + 1;
        no_gaps = 1'b1;
        repeat (24) issue_op(pick_op());
        no_gaps = 1'b0;
    endtask

    initial
    begin : result_sink
        int unsigned mode;
        int unsigned span;
        int          served;
        served = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 48);
            repeat (span)
            begin
                @(posedge clk);
                if (hold_requests != served)
                begin
                    served++;
                    res_if.ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                end
                case (mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= ($urandom_range(0, 9) < 7);
                    2:       res_if.ready <= ($urandom_range(0, 9) < 3);
                    default: res_if.ready <= ~res_if.ready;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int unsigned kind;
        bit          mid_done;
        mid_done = 1'b0;
        rst_n              <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.req_type    <= OP_TICK;
        cmd_if.button_mask <= '0;
        cmd_if.read_index  <= '0;
        cmd_if.new_frame   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(OP_RD_SPL, '0, 0, '0);
        issue(OP_RD_HIS, '0, 63, '0);
        issue(OP_TICK, 10'h3FF, 0, '0);
        issue(OP_TICK, 10'h000, 0, '0);
        issue(OP_RD_HIS, '0, 0, '0);
        issue(OP_RD_HIS, '0, 1, '0);
        issue(OP_RD_HIS, '0, 2, '0);
        issue(OP_SPLIT, '0, 0, '0);
        issue(OP_TOGGLE, '0, 0, '0);
        issue(OP_TICK, 10'h2AA, 0, '0);
        issue(OP_TICK, 10'h155, 0, '0);
        issue(OP_SPLIT, '0, 0, '0);
        issue(OP_TOGGLE, '0, 0, '0);
        issue(OP_RD_SPL, '0, 1, '0);
        issue(OP_RD_SPL, '0, 63, '0);
        issue(OP_LOAD, '0, 0, '0);
        issue(OP_LOAD, '0, 0, 48'h0000_1000_0000);
        issue(OP_TOGGLE, '0, 0, '0);
        issue(OP_LOAD, '0, 0, 48'd5);
        issue(OP_TOGGLE, '0, 0, '0);
        issue(OP_LOAD, '0, 0, {FRAME_BITS{1'b1}});
        issue(OP_RESET, '0, 0, '0);
        issue(OP_TICK, 10'h3FF, 0, '0);
        issue(OP_CLEAR, '0, 0, '0);
        issue(OP_RD_SPL, '0, 0, '0);

        pause_for_results();
        held_burst();
        pause_for_results();

        while (items_sent < RANDOM_ITEMS + 25)
        begin
            if (!mid_done && items_sent > 300)
            begin
                held_burst();
                pause_for_results();
                mid_done = 1'b1;
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2:
                    repeat ($urandom_range(1, 10)) issue_op(pick_op());
                3, 4, 5:
                begin
                    issue_op(OP_RESET);
                    repeat ($urandom_range(2, 8))
                    begin
                        repeat ($urandom_range(0, 4)) issue_op(OP_TICK);
                        if ($urandom_range(0, 3) == 0)
                        begin
                            issue_op(OP_TOGGLE);
                            repeat ($urandom_range(0, 3)) issue_op(OP_TICK);
                            issue_op(OP_TOGGLE);
                        end
                        issue_op(OP_SPLIT);
                    end
                    repeat ($urandom_range(1, 4))
                        issue(OP_RD_SPL, pick_mask(), $urandom_range(0, 35), pick_frame());
                end
                6:
                begin
                    issue_op(OP_CLEAR);
                    repeat ($urandom_range(33, 38))
                    begin
                        repeat ($urandom_range(0, 1)) issue_op(OP_TICK);
                        issue_op(OP_SPLIT);
                    end
                    repeat (4)
                        issue(OP_RD_SPL, pick_mask(), $urandom_range(0, 33), pick_frame());
                end
                7, 8:
                begin
                    repeat ($urandom_range(1, 24)) issue_op(OP_TICK);
                    repeat (3)
                        issue(OP_RD_HIS, pick_mask(), $urandom_range(0, 63), pick_frame());
                end
                default:
                begin
                    issue_op(OP_LOAD);
                    repeat ($urandom_range(0, 3)) issue_op(OP_TICK);
                    if ($urandom_range(0, 1) == 0)
                        issue_op(OP_TOGGLE);
                    issue_op(OP_SPLIT);
                    issue_op(OP_LOAD);
                    issue_op(OP_SPLIT);
                    issue_op(OP_RD_SPL);
                end
            endcase
        end

        pause_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[lap_stopwatch_with_input_trace_top] OK");
        else
            $display("[lap_stopwatch_with_input_trace_top] ERROR");
        $finish;
    end

endmodule
